// File: design/hamu_pkg.sv
// Shared types, constants and saturation helper for the associative memory.
`timescale 1ns / 1ps

package hamu_pkg;

   // matrix shape and field widths
   localparam int DIM           = 4;
   localparam int VEC_W         = 16;
   localparam int W_W           = 32;
   localparam int PROD_W        = W_W + VEC_W;
   localparam int SUM_W         = PROD_W + $clog2(DIM);
   localparam int FRAC_BITS_DEF = 8;

   // action codes
   localparam logic ACT_TRAIN  = 1'b0;
   localparam logic ACT_RECALL = 1'b1;

   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic signed [W_W-1:0]    weight_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   // per-cycle commands from the pipeline control to every row lane
   typedef struct packed {
      logic load;    // new beat captured into stage one
      logic train;   // stage one train item applies its deltas
      logic recall;  // stage one recall item forms its products
   } lane_ctrl_type;

   // clamp a wide signed value into the signed weight range
   function automatic weight_type sat_w(input sum_type v);
      sum_type hi;
      sum_type lo;
      hi = $signed({{(SUM_W - W_W + 1){1'b0}}, {(W_W - 1){1'b1}}});
      lo = $signed({{(SUM_W - W_W + 1){1'b1}}, {(W_W - 1){1'b0}}});
      if (v > hi) begin
         return hi[W_W-1:0];
      end else if (v < lo) begin
         return lo[W_W-1:0];
      end
      return v[W_W-1:0];
   endfunction

endpackage

// File: design/hebbian_associative_memory_unit.sv
// Top level of the 4x4 Hebbian linear associative memory.
//
//  channel | direction | handshake             | payload
//  req_    | in        | req_valid/req_ready   | action, cue_0..3, target_0..3 (Q7.8)
//  rsp_    | out       | rsp_valid/rsp_ready   | recalled_0..3 (Q23.8, saturated)
//
// One beat per cycle while req_ready is high, train and recall mixed freely;
// four row lanes hold the matrix and each does four multiplies per beat.
// A recall result passes the input stage, the product stage and the output
// register in that order. A train beat gives no result.
// Reset clears the weights and all valid flags.
// A stalled rsp_ holds the output; stages behind it keep filling, then req_ready
// drops. Train beats still retire from stage one while the output is blocked.
`timescale 1ns / 1ps

module hebbian_associative_memory_unit import hamu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  vec_type    req_cue_0,
   input  vec_type    req_cue_1,
   input  vec_type    req_cue_2,
   input  vec_type    req_cue_3,
   input  vec_type    req_target_0,
   input  vec_type    req_target_1,
   input  vec_type    req_target_2,
   input  vec_type    req_target_3,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output weight_type rsp_recalled_0,
   output weight_type rsp_recalled_1,
   output weight_type rsp_recalled_2,
   output weight_type rsp_recalled_3
);

   vec_type       req_cue    [DIM];
   vec_type       req_target [DIM];
   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic          s1_action_ff;
   vec_type       s1_cue_ff [DIM];
   logic          s2_valid_ff;
   logic          s2_valid_in;
   logic          s2_free;
   logic          s1_go;
   logic          accept;
   logic          out_free;
   lane_ctrl_type lane_ctrl;
   prod_type      prod_all [DIM][DIM];
   weight_type    recalled [DIM];

   assign req_cue[0]    = req_cue_0;
   assign req_cue[1]    = req_cue_1;
   assign req_cue[2]    = req_cue_2;
   assign req_cue[3]    = req_cue_3;
   assign req_target[0] = req_target_0;
   assign req_target[1] = req_target_1;
   assign req_target[2] = req_target_2;
   assign req_target[3] = req_target_3;

   // pipeline flow: train leaves stage one freely, recall needs stage two room
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_go     = s1_valid_ff && ((s1_action_ff == ACT_TRAIN) || s2_free);
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;

   assign lane_ctrl.load   = accept;
   assign lane_ctrl.train  = s1_go && (s1_action_ff == ACT_TRAIN);
   assign lane_ctrl.recall = s1_go && (s1_action_ff == ACT_RECALL);

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_comb begin
      if (lane_ctrl.recall) begin
         s2_valid_in = 1'b1;
      end else if (out_free) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // stage one payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_action;
         s1_cue_ff    <= req_cue;
      end
   end

   // row lanes
   for (genvar i = 0; i < DIM; i++) begin : g_lane
      hamu_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .req_target (req_target[i]),
         .req_cue    (req_cue),
         .s1_cue     (s1_cue_ff),
         .prod_row   (prod_all[i])
      );
   end

   hamu_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .s2_valid  (s2_valid_ff),
      .prod      (prod_all),
      .rsp_ready (rsp_ready),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .recalled  (recalled)
   );

   assign rsp_recalled_0 = recalled[0];
   assign rsp_recalled_1 = recalled[1];
   assign rsp_recalled_2 = recalled[2];
   assign rsp_recalled_3 = recalled[3];

   // a recall never overwrites products still waiting on a blocked output
   a_no_s2_overrun : assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.recall |-> (!s2_valid_ff || out_free))
      else $error("recall entered a full product stage");

   // a train beat leaves no product behind
   a_train_no_result : assert property (@(posedge clock) disable iff (reset)
      lane_ctrl.train |=> (s2_valid_ff == $past(s2_valid_ff && !out_free)))
      else $error("train beat created a product beat");

   // a result only appears after a product stage beat
   a_rsp_from_s2 : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s2_valid_ff))
      else $error("result raised without a product beat");

   // stage one never accepts over an item that cannot move
   a_s1_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |-> !req_ready)
      else $error("input accepted over a stalled item");

endmodule

// File: design/hamu_lane.sv
// One row lane: Hebb deltas, the row's weight registers and recall products.
`timescale 1ns / 1ps

module hamu_lane import hamu_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  lane_ctrl_type ctrl,
   input  vec_type       req_target,
   input  vec_type       req_cue [DIM],
   input  vec_type       s1_cue [DIM],
   output prod_type      prod_row [DIM]
);

   weight_type delta_ff  [DIM];
   weight_type delta_in  [DIM];
   weight_type weight_ff [DIM];
   weight_type weight_in [DIM];
   prod_type   prod_ff   [DIM];
   prod_type   prod_in   [DIM];

   // delta = (target_i * cue_j) >>> FRAC_BITS, computed at the input
   always_comb begin
      weight_type tc;
      for (int j = 0; j < DIM; j++) begin
         tc          = weight_type'(req_target) * weight_type'(req_cue[j]);
         delta_in[j] = tc >>> FRAC_BITS;
      end
   end

   // saturating accumulate of the registered deltas
   always_comb begin
      sum_type wsum;
      for (int j = 0; j < DIM; j++) begin
         wsum         = sum_type'(weight_ff[j]) + sum_type'(delta_ff[j]);
         weight_in[j] = sat_w(wsum);
      end
   end

   // recall products, each shifted on its own
   always_comb begin
      prod_type full;
      for (int j = 0; j < DIM; j++) begin
         full       = prod_type'(weight_ff[j]) * prod_type'(s1_cue[j]);
         prod_in[j] = full >>> FRAC_BITS;
      end
   end

   // weight row: cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIM; j++) begin
            weight_ff[j] <= '0;
         end
      end else if (ctrl.train) begin
         weight_ff <= weight_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         delta_ff <= delta_in;
      end
      if (ctrl.recall) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_row = prod_ff;

endmodule

// File: design/hamu_merge.sv
// Merging stage: sums each lane's products, saturates and holds the result beat.
`timescale 1ns / 1ps

module hamu_merge import hamu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       s2_valid,
   input  prod_type   prod [DIM][DIM],
   input  logic       rsp_ready,
   output logic       out_free,
   output logic       rsp_valid,
   output weight_type recalled [DIM]
);

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       load;
   weight_type recalled_ff [DIM];
   weight_type recalled_in [DIM];

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = s2_valid && out_free;

   // row sums over the lanes' shifted products
   always_comb begin
      sum_type acc;
      for (int i = 0; i < DIM; i++) begin
         acc = '0;
         for (int j = 0; j < DIM; j++) begin
            acc = acc + sum_type'(prod[i][j]);
         end
         recalled_in[i] = sat_w(acc);
      end
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         recalled_ff <= recalled_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign recalled  = recalled_ff;

endmodule

// File: verif/testbench.sv
// Self-checking bench for the Hebbian associative memory: Hebb training and recall products.
`timescale 1ns / 1ps

module testbench;
   import hamu_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_BEATS = 520;

   localparam vec_type Q_MIN = 16'sh8000;
   localparam vec_type Q_MAX = 16'sh7FFF;
   localparam vec_type Q_ONE = 16'sh0001;
   localparam vec_type Q_NEG = 16'shFFFF;

   // one request beat as the block sees it
   typedef struct packed {
      logic                   action;
      vec_type [DIM-1:0]      cue;
      vec_type [DIM-1:0]      target;
   } memory_beat_type;

   // four recalled rows, element i is row i
   typedef weight_type [DIM-1:0] recall_vec_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic       req_action;
   vec_type    req_cue_0, req_cue_1, req_cue_2, req_cue_3;
   vec_type    req_target_0, req_target_1, req_target_2, req_target_3;
   logic       rsp_valid;
   logic       rsp_ready;
   weight_type rsp_recalled_0, rsp_recalled_1, rsp_recalled_2, rsp_recalled_3;

   memory_beat_type beat_plan_q [$];
   recall_vec_type  recall_due_q [$];
   weight_type      weight_mem [DIM][DIM];

   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  beats_in = 0;
   bit  req_taken = 1'b0;
   bit  beat_held = 1'b0;
   int  send_calm = 0;
   int  recv_calm = 0;

   hebbian_associative_memory_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_cue_0      (req_cue_0),
      .req_cue_1      (req_cue_1),
      .req_cue_2      (req_cue_2),
      .req_cue_3      (req_cue_3),
      .req_target_0   (req_target_0),
      .req_target_1   (req_target_1),
      .req_target_2   (req_target_2),
      .req_target_3   (req_target_3),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_recalled_0 (rsp_recalled_0),
      .rsp_recalled_1 (rsp_recalled_1),
      .rsp_recalled_2 (rsp_recalled_2),
      .rsp_recalled_3 (rsp_recalled_3)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // clamp into the signed 32-bit weight range
   function automatic weight_type clamp_w(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return weight_type'(v);
   endfunction

   // Hebb update on train, matrix-vector product on recall
   function automatic void hebb_predict(input memory_beat_type beat);
      longint         cue_l [DIM];
      longint         tgt_l [DIM];
      longint         acc;
      longint         wl;
      recall_vec_type rows;
      for (int j = 0; j < DIM; j++) begin
         cue_l[j] = longint'($signed(beat.cue[j]));
         tgt_l[j] = longint'($signed(beat.target[j]));
      end
      if (beat.action == ACT_TRAIN) begin
         for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
               wl = longint'(weight_mem[i][j]);
               weight_mem[i][j] = clamp_w(wl + ((tgt_l[i] * cue_l[j]) >>> FRAC_BITS_DEF));
            end
         end
      end else begin
         for (int i = 0; i < DIM; i++) begin
            acc = 0;
            for (int j = 0; j < DIM; j++) begin
               wl = longint'(weight_mem[i][j]);
               acc += (wl * cue_l[j]) >>> FRAC_BITS_DEF;
            end
            rows[i] = clamp_w(acc);
         end
         recall_due_q.push_back(rows);
      end
   endfunction

   function automatic void log_mismatch(input string msg);
      if (mismatch_count < 10) begin
         $display("[%0t] %s", $time, msg);
      end
      mismatch_count++;
   endfunction

   // idle length: mostly none, some short, a few long, with calm stretches
   function automatic int pick_idle(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   // Q7.8 operand: full range, small, extremes or moderate
   function automatic vec_type rand_q78();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2: return vec_type'($urandom);
         3, 4:    return vec_type'(int'($urandom_range(0, 1023)) - 512);
         5: begin
            case ($urandom_range(0, 4))
               0:       return Q_MIN;
               1:       return Q_MAX;
               2:       return '0;
               3:       return Q_NEG;
               default: return Q_ONE;
            endcase
         end
         default: return vec_type'(int'($urandom_range(0, 4095)) - 2048);
      endcase
   endfunction

   function automatic memory_beat_type mk_beat(input logic act,
                                               input vec_type c0, c1, c2, c3,
                                               input vec_type t0, t1, t2, t3);
      memory_beat_type b;
      b.action = act;
      b.cue    = {c3, c2, c1, c0};
      b.target = {t3, t2, t1, t0};
      return b;
   endfunction

   function automatic memory_beat_type rand_beat(input logic act);
      memory_beat_type b;
      b.action = act;
      for (int j = 0; j < DIM; j++) begin
         b.cue[j]    = rand_q78();
         b.target[j] = rand_q78();
      end
      return b;
   endfunction

   // request driver: one beat held until taken, gaps drawn per beat
   always @(negedge clock) begin : req_driver
      memory_beat_type cur;
      int              gap_left;
      if (!reset) begin
         if (beat_held && req_taken) beat_held = 1'b0;
         if (!beat_held) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (beat_plan_q.size() > 0) begin
               cur = beat_plan_q.pop_front();
               beat_held = 1'b1;
               gap_left = pick_idle(send_calm);
               req_action   <= cur.action;
               req_cue_0    <= cur.cue[0];
               req_cue_1    <= cur.cue[1];
               req_cue_2    <= cur.cue[2];
               req_cue_3    <= cur.cue[3];
               req_target_0 <= cur.target[0];
               req_target_1 <= cur.target[1];
               req_target_2 <= cur.target[2];
               req_target_3 <= cur.target[3];
            end
         end
         req_valid <= beat_held;
      end
   end

   // result receiver: random stalls plus a long hold-off now and then
   always @(negedge clock) begin : rsp_receiver
      int hold_left;
      int stall_left;
      int next_hold_at;
      if (reset) begin
         hold_left    = 0;
         stall_left   = 0;
         next_hold_at = 60;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (beats_in >= next_hold_at) begin
         hold_left    = 150;
         next_hold_at = next_hold_at + 400;
         rsp_ready   <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         stall_left = pick_idle(recv_calm);
         rsp_ready <= 1'b1;
      end
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin : beat_monitor
      memory_beat_type seen;
      recall_vec_type  got;
      recall_vec_type  want;
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_taken <= 1'b0;
         for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) weight_mem[i][j] = '0;
         end
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            seen = mk_beat(req_action, req_cue_0, req_cue_1, req_cue_2, req_cue_3,
                           req_target_0, req_target_1, req_target_2, req_target_3);
            hebb_predict(seen);
            beats_in <= beats_in + 1;
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_recalled_3, rsp_recalled_2, rsp_recalled_1, rsp_recalled_0};
            if (recall_due_q.size() == 0) begin
               log_mismatch($sformatf("result with no recall pending: %0d %0d %0d %0d",
                                      got[0], got[1], got[2], got[3]));
            end else begin
               want = recall_due_q.pop_front();
               for (int i = 0; i < DIM; i++) begin
                  if (got[i] !== want[i]) begin
                     log_mismatch($sformatf("recalled_%0d: expected %0d, got %0d",
                                            i, want[i], got[i]));
                  end
               end
            end
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // stimulus plan, reset and end of run
   initial begin : stimulus
      memory_beat_type b;
      vec_type         seq_cue [3][DIM];
      int              n_train;
      int              made;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_action   = ACT_TRAIN;
      req_cue_0    = '0;
      req_cue_1    = '0;
      req_cue_2    = '0;
      req_cue_3    = '0;
      req_target_0 = '0;
      req_target_1 = '0;
      req_target_2 = '0;
      req_target_3 = '0;
      rsp_ready    = 1'b0;

      // directed: empty matrix, extremes, truncation toward minus infinity,
      // recall saturation both ways, ignored targets on recall
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_MAX, Q_MIN, '0, Q_NEG,
                                    Q_MAX, Q_MAX, Q_MIN, Q_MIN));
      beat_plan_q.push_back(mk_beat(ACT_TRAIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                    Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                    '0, '0, '0, '0));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    '0, '0, '0, '0));
      beat_plan_q.push_back(mk_beat(ACT_TRAIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                    Q_MIN, Q_MIN, Q_MIN, Q_MIN));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
                                    Q_MAX, Q_NEG, Q_ONE, '0));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    '0, '0, '0, '0));
      beat_plan_q.push_back(mk_beat(ACT_TRAIN, Q_NEG, Q_ONE, Q_MAX, Q_MIN,
                                    Q_MAX, Q_NEG, Q_ONE, '0));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_ONE, Q_NEG, 16'sh0100, 16'shFF00,
                                    '0, '0, '0, '0));
      beat_plan_q.push_back(mk_beat(ACT_TRAIN, 16'sh1234, Q_NEG, 16'sh8001, 16'sh00FF,
                                    '0, '0, '0, '0));
      beat_plan_q.push_back(mk_beat(ACT_TRAIN, '0, '0, '0, '0,
                                    Q_MAX, Q_MIN, Q_NEG, Q_ONE));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, '0, '0, '0, '0,
                                    Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      beat_plan_q.push_back(mk_beat(ACT_TRAIN, Q_NEG, Q_NEG, Q_ONE, Q_ONE,
                                    Q_ONE, Q_NEG, Q_ONE, Q_NEG));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_NEG, Q_ONE, Q_NEG, Q_ONE,
                                    '0, '0, '0, '0));
      beat_plan_q.push_back(mk_beat(ACT_TRAIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    Q_MIN, Q_MAX, Q_MIN, Q_MAX));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                                    '0, '0, '0, '0));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, 16'sh0080, 16'shFF80, 16'sh0001, 16'sh7F00,
                                    '0, '0, '0, '0));

      // random: mostly store-then-recall sequences, the rest loose beats
      made = 0;
      while (made < RANDOM_BEATS) begin
         if ($urandom_range(0, 9) < 6) begin
            n_train = $urandom_range(1, 3);
            for (int k = 0; k < n_train; k++) begin
               b = rand_beat(ACT_TRAIN);
               for (int j = 0; j < DIM; j++) seq_cue[k][j] = b.cue[j];
               beat_plan_q.push_back(b);
            end
            for (int k = 0; k < n_train; k++) begin
               b = rand_beat(ACT_RECALL);
               if ($urandom_range(0, 3) != 0) begin
                  for (int j = 0; j < DIM; j++) b.cue[j] = seq_cue[k][j];
               end
               beat_plan_q.push_back(b);
            end
            made += 2 * n_train;
         end else begin
            beat_plan_q.push_back(rand_beat($urandom_range(0, 1) ? ACT_RECALL : ACT_TRAIN));
            made++;
         end
      end

      // closing beats: single-element cues, a full-scale cue, then a full-scale
      // train and a mixed recall
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_ONE, '0, '0, '0, '0, '0, '0, '0));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_NEG, '0, '0, '0, '0, '0, '0, '0));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    '0, '0, '0, '0));
      beat_plan_q.push_back(mk_beat(ACT_TRAIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                    Q_MAX, Q_MAX, Q_MAX, Q_MAX));
      beat_plan_q.push_back(mk_beat(ACT_RECALL, Q_ONE, Q_NEG, 16'sh0100, 16'shFF00,
                                    '0, '0, '0, '0));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // wait for the plan to drain, then for outstanding recalls
      while (beat_plan_q.size() > 0 || beat_held) @(posedge clock);
      while (recall_due_q.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
